[rtl/pfs_pkg.sv]
// ----------------------------------------------------------------------------
// Periodic five-point stencil: shared package
// Types, register indexes, opcodes and fixed widths that the stencil engine,
// its arithmetic pipeline and its ports all use.
// ----------------------------------------------------------------------------
package pfs_pkg;

  // Fixed field widths.
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned INDEX_W   = 10;
  localparam int unsigned COUNT_W   = 11;
  localparam int unsigned PASS_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // Stencil shape: five taps centered on the output sample.
  localparam int unsigned TAPS      = 5;
  localparam int unsigned HALF_TAPS = TAPS / 2;

  // Register reset values.
  localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RST = 11'd1024;
  localparam logic [PASS_W-1:0]  PASS_COUNT_RST   = 16'd1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEFF_0      = 3'd0,
    REG_COEFF_1      = 3'd1,
    REG_COEFF_2      = 3'd2,
    REG_COEFF_3      = 3'd3,
    REG_COEFF_4      = 3'd4,
    REG_SAMPLE_COUNT = 3'd5,
    REG_PASS_COUNT   = 3'd6
  } cfg_reg_e;

  // Command opcodes.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2
  } opcode_e;

  // Result kinds and status codes.
  typedef enum logic {
    KIND_READ = 1'b0,
    KIND_RUN  = 1'b1
  } kind_e;

  typedef enum logic {
    STATUS_OK        = 1'b0,
    STATUS_BAD_INDEX = 1'b1
  } status_e;

  // Control state of the engine.
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef word_t [TAPS-1:0]         taps_t;

  // One command word.
  typedef struct packed {
    logic [1:0]         opcode;
    logic [INDEX_W-1:0] index;
    word_t              sample_in;
  } in_item_t;

  // One result word.
  typedef struct packed {
    logic  kind;
    word_t sample_out;
    logic  status;
    logic  saturated;
  } out_item_t;

  // Output of the multiply-accumulate pipeline.
  typedef struct packed {
    logic  valid;
    logic  sat;
    word_t y;
  } mac_out_t;

endpackage

[rtl/pfs_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module pfs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/pfs_datapath.sv]
// ----------------------------------------------------------------------------
// Stencil multiply-accumulate pipeline
// Five products, an exact sum in three adder stages, round to nearest and
// saturation to 32 bits. One output sample per cycle.
// ----------------------------------------------------------------------------
module pfs_datapath #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  pfs_pkg::taps_t   coeff_i,
  input  pfs_pkg::taps_t   win_i,
  output pfs_pkg::mac_out_t mac_o
);
  import pfs_pkg::*;

  localparam int unsigned PW = 2 * WORD_W;
  localparam int unsigned SW = PW + $clog2(TAPS);
  localparam logic signed [SW-1:0] RND = SW'(1) << (FRAC_BITS - 1);
  localparam word_t WORD_MAX = {1'b0, {(WORD_W - 1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_W - 1){1'b0}}};

  logic signed [PW-1:0] prod_q [TAPS];
  logic signed [SW-1:0] s01_q, s23_q, p4_q;
  logic signed [SW-1:0] s0123_q, p4b_q;
  logic signed [SW-1:0] tot_q;
  logic [3:0]           v_q;
  logic signed [SW-1:0] shifted;
  logic                 fits;

  // Stage valids.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[2:0], in_valid_i};
    end
  end

  // Products, then the sum in three steps; the rounding constant rides on
  // the last tap so that no stage adds more than two terms.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < TAPS; k++) begin
      prod_q[k] <= $signed(coeff_i[k]) * $signed(win_i[k]);
    end
    s01_q   <= SW'(prod_q[0]) + SW'(prod_q[1]);
    s23_q   <= SW'(prod_q[2]) + SW'(prod_q[3]);
    p4_q    <= SW'(prod_q[4]) + RND;
    s0123_q <= s01_q + s23_q;
    p4b_q   <= p4_q;
    tot_q   <= s0123_q + p4b_q;
  end

  // Floor after the rounding add, then clamp to the 32-bit range.
  always_comb begin
    shifted = tot_q >>> FRAC_BITS;
    fits    = (shifted[SW-1:WORD_W-1] == {(SW - WORD_W + 1){shifted[WORD_W-1]}});
    mac_o.valid = v_q[3];
    mac_o.sat   = v_q[3] && !fits;
    if (fits) begin
      mac_o.y = shifted[WORD_W-1:0];
    end else if (shifted[SW-1]) begin
      mac_o.y = WORD_MIN;
    end else begin
      mac_o.y = WORD_MAX;
    end
  end

endmodule

[rtl/periodic_five_point_stencil_top.sv]
// ----------------------------------------------------------------------------
// Periodic five-point stencil engine
// Two banks of signed Q16.16 samples; write, read and run commands.
// ----------------------------------------------------------------------------
// Usage:
//   A command word on cmd_i is taken at a clock edge with start_i high and
//   busy_o low. Write stores one sample into the current bank and gives no
//   result. Read gives one result word in the cycle after it is taken. Run
//   applies pass_count stencil passes with periodic wrap and then gives one
//   run-done word. Results appear on result_o for exactly one cycle, marked
//   by done_o; the receiver cannot hold them off.
//   Write and read may follow back to back. A run holds busy_o high while it
//   applies pass_count passes, n being the samples in use: each pass streams
//   the source bank through its single read port, one sample a cycle (n + 4
//   reads), then lets the window and the multiply-accumulate pipeline drain.
//   busy_o drops and the run-done word appears in the same cycle.
//   Configuration goes through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user
//   is to write it only while the engine is idle, which the block does not
//   enforce. Reset loads the register reset values, selects bank A and
//   clears the saturation flag; sample memory is not cleared.
// ----------------------------------------------------------------------------
module periodic_five_point_stencil_top #(
  parameter int unsigned MAX_SAMPLES = 1024,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  pfs_pkg::in_item_t              cmd_i,
  output logic                           busy_o,
  output logic                           done_o,
  output pfs_pkg::out_item_t             result_o,
  input  logic                           cfg_we_i,
  input  logic [pfs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pfs_pkg::WORD_W-1:0]     cfg_wdata_i
);
  import pfs_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_SAMPLES);
  localparam int unsigned CW  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned RW  = $clog2(MAX_SAMPLES + TAPS);
  localparam int unsigned WCW = $clog2(TAPS);
  localparam logic [WCW-1:0] WIN_FULL = WCW'(TAPS - 1);

  // Configuration registers.
  taps_t              coeff_q;
  logic [COUNT_W-1:0] cfg_count_q;
  logic [PASS_W-1:0]  cfg_pass_q;

  // Control state.
  state_e            state_q, state_d;
  logic              cur_q, cur_d;
  logic              sat_q, sat_d;
  logic [PASS_W-1:0] pass_left_q, pass_left_d;
  logic [AW-1:0]     rd_addr_q, rd_addr_d;
  logic [RW-1:0]     rd_cnt_q, rd_cnt_d;
  logic              rv_q, rv_d;
  logic [WCW-1:0]    win_cnt_q, win_cnt_d;
  logic              wv_q, wv_d;
  logic [AW-1:0]     wr_idx_q, wr_idx_d;
  taps_t             win_q, win_d;

  // Result register.
  logic res_valid_q, res_valid_d;
  logic res_kind_q, res_kind_d;
  logic res_bad_q, res_bad_d;
  logic res_sel_q, res_sel_d;
  logic res_sat_q, res_sat_d;

  // Derived sizes.
  logic [CW-1:0] n;
  logic [AW-1:0] n_m1;
  logic [AW-1:0] start_addr;
  logic [RW-1:0] rd_total;
  logic          idx_ok;

  // Bank ports.
  logic [1:0]    bank_we;
  logic [AW-1:0] bank_waddr;
  logic [AW-1:0] bank_raddr;
  word_t         bank_wdata;
  word_t         bank_rdata [2];

  mac_out_t mac;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q     <= '0;
      cfg_count_q <= SAMPLE_COUNT_RST;
      cfg_pass_q  <= PASS_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i) inside
        REG_COEFF_0, REG_COEFF_1, REG_COEFF_2, REG_COEFF_3, REG_COEFF_4: begin
          coeff_q[cfg_idx_i] <= cfg_wdata_i;
        end
        REG_SAMPLE_COUNT: begin
          cfg_count_q <= cfg_wdata_i[COUNT_W-1:0];
        end
        REG_PASS_COUNT: begin
          cfg_pass_q <= cfg_wdata_i[PASS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Samples in use: zero counts as one, values above the bank depth clamp.
  always_comb begin
    if (cfg_count_q == '0) begin
      n = CW'(1);
    end else if (32'(cfg_count_q) > 32'(MAX_SAMPLES)) begin
      n = CW'(MAX_SAMPLES);
    end else begin
      n = CW'(cfg_count_q);
    end
    n_m1       = AW'(n - CW'(1));
    start_addr = (n >= CW'(HALF_TAPS)) ? AW'(n - CW'(HALF_TAPS)) : '0;
    rd_total   = RW'(n) + RW'(TAPS - 1);
    idx_ok     = 32'(cmd_i.index) < 32'(n);
  end

  // Sample banks.
  for (genvar b = 0; b < 2; b++) begin : g_bank
    pfs_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_SAMPLES)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (bank_we[b]),
      .waddr_i (bank_waddr),
      .wdata_i (bank_wdata),
      .raddr_i (bank_raddr),
      .rdata_o (bank_rdata[b])
    );
  end

  // Multiply-accumulate pipeline.
  pfs_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (wv_q),
    .coeff_i    (coeff_q),
    .win_i      (win_q),
    .mac_o      (mac)
  );

  // Command decode and the run sequencer.
  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    sat_d       = sat_q;
    pass_left_d = pass_left_q;
    rd_addr_d   = rd_addr_q;
    rd_cnt_d    = rd_cnt_q;
    rv_d        = 1'b0;
    win_cnt_d   = win_cnt_q;
    wv_d        = 1'b0;
    wr_idx_d    = wr_idx_q;
    win_d       = win_q;
    res_valid_d = 1'b0;
    res_kind_d  = res_kind_q;
    res_bad_d   = res_bad_q;
    res_sel_d   = res_sel_q;
    bank_we     = '0;
    bank_waddr  = AW'(cmd_i.index);
    bank_raddr  = AW'(cmd_i.index);
    bank_wdata  = cmd_i.sample_in;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (cmd_i.opcode)
            OP_WRITE: begin
              if (idx_ok) begin
                bank_we[cur_q] = 1'b1;
                sat_d          = 1'b0;
              end
            end
            OP_RUN: begin
              if (cfg_pass_q == '0) begin
                res_valid_d = 1'b1;
                res_kind_d  = KIND_RUN;
                res_bad_d   = STATUS_OK;
              end else begin
                state_d     = ST_RUN;
                pass_left_d = cfg_pass_q;
                rd_addr_d   = start_addr;
                rd_cnt_d    = '0;
                win_cnt_d   = '0;
                wr_idx_d    = '0;
              end
            end
            OP_READ: begin
              res_valid_d = 1'b1;
              res_kind_d  = KIND_READ;
              res_bad_d   = idx_ok ? STATUS_OK : STATUS_BAD_INDEX;
              res_sel_d   = cur_q;
            end
            default: begin
            end
          endcase
        end
      end

      ST_RUN: begin
        bank_raddr = rd_addr_q;
        bank_waddr = wr_idx_q;
        bank_wdata = mac.y;

        // Stream the source bank, wrapping at the period.
        if (rd_cnt_q != rd_total) begin
          rv_d      = 1'b1;
          rd_cnt_d  = rd_cnt_q + RW'(1);
          rd_addr_d = (rd_addr_q == n_m1) ? '0 : rd_addr_q + AW'(1);
        end

        // Shift the returning sample into the five-tap window.
        if (rv_q) begin
          for (int k = 0; k < TAPS - 1; k++) begin
            win_d[k] = win_q[k + 1];
          end
          win_d[TAPS-1] = bank_rdata[cur_q];
          wv_d          = (win_cnt_q == WIN_FULL);
          if (win_cnt_q != WIN_FULL) begin
            win_cnt_d = win_cnt_q + WCW'(1);
          end
        end

        // Write each result into the other bank; the last one ends the pass.
        if (mac.valid) begin
          bank_we[cur_q ^ 1'b1] = 1'b1;
          if (mac.sat) begin
            sat_d = 1'b1;
          end
          if (wr_idx_q == n_m1) begin
            cur_d = cur_q ^ 1'b1;
            if (pass_left_q == PASS_W'(1)) begin
              state_d     = ST_IDLE;
              res_valid_d = 1'b1;
              res_kind_d  = KIND_RUN;
              res_bad_d   = STATUS_OK;
            end else begin
              pass_left_d = pass_left_q - PASS_W'(1);
              rd_addr_d   = start_addr;
              rd_cnt_d    = '0;
              win_cnt_d   = '0;
              wr_idx_d    = '0;
            end
          end else begin
            wr_idx_d = wr_idx_q + AW'(1);
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res_sat_d = sat_d;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_q       <= 1'b0;
      sat_q       <= 1'b0;
      pass_left_q <= '0;
      rd_addr_q   <= '0;
      rd_cnt_q    <= '0;
      rv_q        <= 1'b0;
      win_cnt_q   <= '0;
      wv_q        <= 1'b0;
      wr_idx_q    <= '0;
      res_valid_q <= 1'b0;
      res_kind_q  <= KIND_READ;
      res_bad_q   <= STATUS_OK;
      res_sel_q   <= 1'b0;
      res_sat_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      sat_q       <= sat_d;
      pass_left_q <= pass_left_d;
      rd_addr_q   <= rd_addr_d;
      rd_cnt_q    <= rd_cnt_d;
      rv_q        <= rv_d;
      win_cnt_q   <= win_cnt_d;
      wv_q        <= wv_d;
      wr_idx_q    <= wr_idx_d;
      res_valid_q <= res_valid_d;
      res_kind_q  <= res_kind_d;
      res_bad_q   <= res_bad_d;
      res_sel_q   <= res_sel_d;
      res_sat_q   <= res_sat_d;
    end
  end

  // Sample window.
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  // Outputs. Read data comes straight from the bank's read register.
  assign busy_o = (state_q != ST_IDLE);
  assign done_o = res_valid_q;

  always_comb begin
    result_o.kind      = res_kind_q;
    result_o.status    = res_bad_q;
    result_o.saturated = res_sat_q;
    if (res_kind_q == KIND_READ && res_bad_q == STATUS_OK) begin
      result_o.sample_out = bank_rdata[res_sel_q];
    end else begin
      result_o.sample_out = '0;
    end
  end

  // The read stream and the pipeline are empty whenever the engine is idle.
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !(rv_q || wv_q || mac.valid))
    else $error("stencil pipeline busy while idle");

  // A pass ends only after every read of the source bank was issued.
  a_pass_end_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && mac.valid && wr_idx_q == n_m1) |-> (rd_cnt_q == rd_total))
    else $error("pass ended with reads outstanding");

  // A run-done word carries no sample and an ok status.
  a_run_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.kind == KIND_RUN) |->
      (result_o.status == STATUS_OK && result_o.sample_out == '0))
    else $error("run-done word carries data");

  // Only an accepted run command makes the engine busy.
  a_busy_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i && cmd_i.opcode == OP_RUN))
    else $error("busy without a run command");

endmodule

[test/periodic_five_point_stencil_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Periodic five-point stencil: result checker
// Watches the command, configuration and result channels of the stencil
// engine. Keeps its own copy of both sample banks, the weights and the
// sticky saturation flag, predicts every result word when a command is
// taken, and compares each result word field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module periodic_five_point_stencil_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  pfs_pkg::in_item_t             cmd_i,
  input  logic                          busy_i,
  input  logic                          done_i,
  input  pfs_pkg::out_item_t            result_i,
  input  logic                          cfg_we_i,
  input  logic [pfs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pfs_pkg::WORD_W-1:0]    cfg_wdata_i,
  output int                            words_due_o,
  output int                            mismatches_o
);
  import pfs_pkg::*;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned FRAC  = 16;

  // Predicted contents of the engine.
  word_t              samples [2][DEPTH];
  word_t              weights [TAPS];
  logic               live_bank;
  logic               sat_sticky;
  logic [COUNT_W-1:0] count_reg;
  logic [PASS_W-1:0]  pass_reg;

  out_item_t due_words [$];
  int        words_due  = 0;
  int        mismatches = 0;

  assign words_due_o  = words_due;
  assign mismatches_o = mismatches;

  // Samples in use: zero means one, anything above the store means all of it.
  function automatic int unsigned samples_in_use(input logic [COUNT_W-1:0] count);
    if (count == 0) return 1;
    if (count > DEPTH) return DEPTH;
    return 32'(count);
  endfunction

  // One output point: exact five-term sum, round half up, clip to 32 bits.
  function automatic word_t filtered_point(input logic src, input int unsigned n,
                                           input int unsigned pos, output logic clipped);
    logic signed [67:0] acc;
    logic signed [67:0] tap;
    logic signed [67:0] smp;
    int unsigned        k;
    acc = '0;
    for (int j = 0; j < TAPS; j++) begin
      k   = (pos + j + 2 * n - HALF_TAPS) % n;
      tap = 68'(weights[j]);
      smp = 68'(samples[src][k]);
      acc = acc + tap * smp;
    end
    acc = acc + (68'sd1 <<< (FRAC - 1));
    acc = acc >>> FRAC;
    clipped = 1'b1;
    if (acc > 68'sd2147483647) return word_t'(32'h7FFF_FFFF);
    if (acc < -68'sd2147483648) return word_t'(32'h8000_0000);
    clipped = 1'b0;
    return word_t'(acc[WORD_W-1:0]);
  endfunction

  // Compare finished words first, then apply configuration and commands.
  always @(posedge clk_i or negedge rst_ni) begin : track
    int unsigned n;
    logic        clipped;
    out_item_t   want;
    if (!rst_ni) begin
      for (int j = 0; j < TAPS; j++) weights[j] = '0;
      count_reg  = SAMPLE_COUNT_RST;
      pass_reg   = PASS_COUNT_RST;
      live_bank  = 1'b0;
      sat_sticky = 1'b0;
      due_words.delete();
      words_due  = 0;
    end else begin
      if (done_i) begin
        if (due_words.size() == 0) begin
          $error("result word with none due: kind %0d sample_out %0d status %0d saturated %0d",
                 result_i.kind, result_i.sample_out, result_i.status, result_i.saturated);
          mismatches++;
        end else begin
          want = due_words.pop_front();
          if (result_i.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, result_i.kind);
            mismatches++;
          end
          if (result_i.sample_out !== want.sample_out) begin
            $error("sample_out: expected %0d, got %0d", want.sample_out, result_i.sample_out);
            mismatches++;
          end
          if (result_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result_i.status);
            mismatches++;
          end
          if (result_i.saturated !== want.saturated) begin
            $error("saturated: expected %0d, got %0d", want.saturated, result_i.saturated);
            mismatches++;
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_idx_i) inside
          REG_COEFF_0, REG_COEFF_1, REG_COEFF_2, REG_COEFF_3, REG_COEFF_4: begin
            weights[cfg_idx_i] = cfg_wdata_i;
          end
          REG_SAMPLE_COUNT: count_reg = cfg_wdata_i[COUNT_W-1:0];
          REG_PASS_COUNT:   pass_reg  = cfg_wdata_i[PASS_W-1:0];
          default: ;
        endcase
      end

      if (start_i && !busy_i) begin
        n = samples_in_use(count_reg);
        case (cmd_i.opcode)
          OP_WRITE: begin
            // Only a write that lands in range clears the sticky flag.
            if (cmd_i.index < n) begin
              samples[live_bank][cmd_i.index] = cmd_i.sample_in;
              sat_sticky = 1'b0;
            end
          end
          OP_RUN: begin
            for (int unsigned p = 0; p < pass_reg; p++) begin
              for (int unsigned i = 0; i < n; i++) begin
                samples[!live_bank][i] = filtered_point(live_bank, n, i, clipped);
                if (clipped) sat_sticky = 1'b1;
              end
              live_bank = !live_bank;
            end
            want.kind       = KIND_RUN;
            want.sample_out = '0;
            want.status     = STATUS_OK;
            want.saturated  = sat_sticky;
            due_words.push_back(want);
          end
          OP_READ: begin
            want.kind = KIND_READ;
            if (cmd_i.index < n) begin
              want.sample_out = samples[live_bank][cmd_i.index];
              want.status     = STATUS_OK;
            end else begin
              want.sample_out = '0;
              want.status     = STATUS_BAD_INDEX;
            end
            want.saturated = sat_sticky;
            due_words.push_back(want);
          end
          default: ;
        endcase
      end
      words_due = due_words.size();
    end
  end

endmodule

[test/periodic_five_point_stencil_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Periodic five-point stencil: testbench top
// Drives write, read and run commands and register settings into the
// stencil engine: a directed opening over extreme samples and weights,
// rounding ties, saturation, bad indexes, tiny sample counts and zero and
// maximum pass counts, then random phases with random settings and
// oversized counts. A separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module periodic_five_point_stencil_top_test;
  import pfs_pkg::*;

  localparam int unsigned DEPTH         = 1024;
  localparam int unsigned ITEM_TARGET   = 700;
  // Random runs only on short banks, so that filling a bank stays cheap.
  localparam int unsigned RUN_LEN_MAX   = 64;
  localparam int unsigned SETTLE_CYCLES = 16;
  // Longest quiet stretch is a run of the largest pass count on one sample.
  // The limit takes that several times over.
  localparam int unsigned QUIET_LIMIT   = 3_000_000;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  in_item_t             cmd_i;
  logic                 busy_o;
  logic                 done_o;
  out_item_t            result_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [WORD_W-1:0]    cfg_wdata_i;

  int          words_due;
  int          mismatches;
  int unsigned quiet_cycles;

  // What the stimulus knows of the engine, so that it never reads a
  // sample that was never written.
  bit          filled [2][DEPTH];
  bit          live_bank;
  int unsigned live_len;
  int unsigned live_passes;
  bit          gaps_on;
  // Every command word taken by the engine, directed ones included.
  int unsigned items_sent;

  periodic_five_point_stencil_top dut (
    .clk_i, .rst_ni, .start_i, .cmd_i, .busy_o, .done_o, .result_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  periodic_five_point_stencil_checker stencil_check (
    .clk_i, .rst_ni, .start_i, .cmd_i,
    .busy_i       (busy_o),
    .done_i       (done_o),
    .result_i     (result_o),
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .words_due_o  (words_due),
    .mismatches_o (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: too long without any word moving on any channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("periodic_five_point_stencil_top verification failed");
      $finish;
    end
  end

  function automatic int unsigned samples_in_use(input logic [COUNT_W-1:0] count);
    if (count == 0) return 1;
    if (count > DEPTH) return DEPTH;
    return 32'(count);
  endfunction

  // Samples: extremes, small values near zero, and anything at all.
  function automatic word_t rand_sample();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8) return word_t'(32'h7FFF_FFFF);
    if (pick < 16) return word_t'(32'h8000_0000);
    if (pick < 70) return word_t'($urandom_range(32'h0008_0000)) - word_t'(32'h0004_0000);
    return word_t'($urandom());
  endfunction

  // Weights: small ones keep values alive over passes, wide ones saturate.
  function automatic word_t rand_weight(input bit wide);
    if (wide) begin
      if ($urandom_range(3) == 0) begin
        return $urandom_range(1) ? word_t'(32'h7FFF_FFFF) : word_t'(32'h8000_0000);
      end
      return word_t'($urandom());
    end
    return word_t'($urandom_range(32'h0003_0000)) - word_t'(32'h0001_8000);
  endfunction

  // Send one command word and hold it until the engine takes it.
  task automatic send(input logic [1:0] op, input int unsigned idx, input word_t value);
    in_item_t item;
    item.opcode    = op;
    item.index     = idx[INDEX_W-1:0];
    item.sample_in = value;
    start_i <= 1'b1;
    cmd_i   <= item;
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    items_sent++;

    // Track which entries now hold data, and which bank is current.
    if (op == OP_WRITE && idx < live_len) filled[live_bank][idx] = 1'b1;
    if (op == OP_RUN) begin
      for (int unsigned i = 0; i < live_len; i++) begin
        if (live_passes >= 1) filled[!live_bank][i] = 1'b1;
        if (live_passes >= 2) filled[live_bank][i] = 1'b1;
      end
      if (live_passes[0]) live_bank = !live_bank;
    end

    if (gaps_on && $urandom_range(99) < 15) begin
      start_i <= 1'b0;
      repeat ($urandom_range(18, 1)) @(posedge clk_i);
    end
  endtask

  // Let every due word arrive, then a few more cycles for stray ones.
  task automatic settle();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (words_due != 0) @(negedge clk_i);
    @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write every register; only while the engine is idle.
  task automatic program_regs(input taps_t weights, input logic [WORD_W-1:0] count_word,
                              input logic [WORD_W-1:0] pass_word);
    cfg_we_i <= 1'b1;
    for (int t = 0; t < TAPS; t++) begin
      cfg_idx_i   <= CFG_IDX_W'(int'(REG_COEFF_0) + t);
      cfg_wdata_i <= weights[t];
      @(posedge clk_i);
    end
    cfg_idx_i   <= REG_SAMPLE_COUNT;
    cfg_wdata_i <= count_word;
    @(posedge clk_i);
    cfg_idx_i   <= REG_PASS_COUNT;
    cfg_wdata_i <= pass_word;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    live_len    = samples_in_use(count_word[COUNT_W-1:0]);
    live_passes = 32'(pass_word[PASS_W-1:0]);
  endtask

  // Write any sample in use that the current bank does not hold yet.
  task automatic fill_bank();
    for (int unsigned i = 0; i < live_len; i++) begin
      if (!filled[live_bank][i]) send(OP_WRITE, i, rand_sample());
    end
  endtask

  // One phase of random settings and a random mix of commands.
  task automatic random_phase(input int unsigned phase_no);
    taps_t             weights;
    logic [WORD_W-1:0] count_word;
    logic [WORD_W-1:0] pass_word;
    int unsigned       pick;
    int unsigned       idx;
    int unsigned       ops;
    bit                wide;
    wide = ($urandom_range(99) < 30);
    for (int t = 0; t < TAPS; t++) weights[t] = rand_weight(wide);
    pick = $urandom_range(99);
    if (phase_no == 0) count_word = $urandom_range(2047, DEPTH + 1);
    else if (phase_no == 1) count_word = DEPTH;
    else if (pick < 5) count_word = $urandom_range(4);
    else if (pick < 9) count_word = $urandom_range(2047, 1000);
    else count_word = $urandom_range(48, 5);
    pass_word = ($urandom_range(99) < 10) ? $urandom_range(8, 4) : $urandom_range(3);
    // Bits above each register's width must not matter.
    if ($urandom_range(1)) begin
      count_word[WORD_W-1:COUNT_W] = (WORD_W - COUNT_W)'($urandom());
      pass_word[WORD_W-1:PASS_W]   = (WORD_W - PASS_W)'($urandom());
    end
    program_regs(weights, count_word, pass_word);

    ops = $urandom_range(50, 25);
    for (int unsigned k = 0; k < ops && items_sent < ITEM_TARGET; k++) begin
      // The last stretch of the run goes without idling.
      gaps_on = (items_sent < ITEM_TARGET * 85 / 100);
      pick = $urandom_range(99);
      if (pick < 5) begin
        send(OP_UNUSED, $urandom_range(DEPTH - 1), word_t'($urandom()));
      end else if (pick < 15) begin
        // A run reads every sample in use, so only short banks get one.
        if (live_len <= RUN_LEN_MAX) begin
          fill_bank();
          send(OP_RUN, $urandom_range(DEPTH - 1), word_t'($urandom()));
        end
      end else if (pick < 55) begin
        if (live_len < DEPTH && $urandom_range(99) < 12) idx = $urandom_range(DEPTH - 1, live_len);
        else idx = $urandom_range(live_len - 1, 0);
        send(OP_WRITE, idx, rand_sample());
      end else begin
        if (live_len < DEPTH && $urandom_range(99) < 15) idx = $urandom_range(DEPTH - 1, live_len);
        else idx = $urandom_range(live_len - 1, 0);
        if (idx < live_len && !filled[live_bank][idx]) send(OP_WRITE, idx, rand_sample());
        send(OP_READ, idx, word_t'($urandom()));
      end
    end
    settle();
  endtask

  initial begin : stimulus
    taps_t       weights;
    int unsigned phase_no;
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    cmd_i       <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_wdata_i <= '0;
    live_bank   = 1'b0;
    live_len    = samples_in_use(SAMPLE_COUNT_RST);
    live_passes = 32'(PASS_COUNT_RST);
    gaps_on     = 1'b1;
    items_sent  = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: the top entry, and an unused opcode.
    send(OP_WRITE, DEPTH - 1, word_t'(32'h7FFF_FFFF));
    send(OP_READ, DEPTH - 1, '0);
    send(OP_UNUSED, 5, word_t'(32'h1234_5678));
    settle();

    // Extreme weights and samples saturate; an ignored write keeps the
    // flag, a write in range clears it.
    weights = {32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_8000, 32'h0000_8000};
    program_regs(weights, 6, 1);
    send(OP_WRITE, 0, word_t'(32'h7FFF_FFFF));
    send(OP_WRITE, 1, word_t'(32'h8000_0000));
    send(OP_WRITE, 2, word_t'(32'h0000_0001));
    send(OP_WRITE, 3, word_t'(32'hFFFF_FFFF));
    send(OP_WRITE, 4, word_t'(32'h0001_0000));
    send(OP_WRITE, 5, word_t'(32'hFFFF_0000));
    send(OP_RUN, 0, '0);
    send(OP_READ, 2, '0);
    send(OP_READ, 6, '0);
    send(OP_WRITE, DEPTH - 1, word_t'(32'h0000_5555));
    send(OP_READ, 1, '0);
    send(OP_WRITE, 3, word_t'(32'h0002_0000));
    send(OP_READ, 3, '0);
    settle();

    // A zero sample count means one sample; halves give ties either side
    // of zero, which round up.
    weights = {TAPS{32'h0000_8000}};
    program_regs(weights, 0, 1);
    send(OP_WRITE, 0, word_t'(32'h0000_0001));
    send(OP_RUN, 0, '0);
    send(OP_READ, 0, '0);
    send(OP_WRITE, 0, word_t'(32'hFFFF_FFFF));
    send(OP_RUN, 0, '0);
    send(OP_READ, 0, '0);
    send(OP_READ, DEPTH - 1, '0);
    settle();

    // Fewer samples than taps, and a run of zero passes.
    weights = {32'h0000_4000, 32'hFFFF_0000, 32'h0002_0000, 32'h0000_0000, 32'hFFFF_C000};
    program_regs(weights, 4, 0);
    fill_bank();
    send(OP_RUN, 0, '0);
    send(OP_READ, 3, '0);
    send(OP_READ, 4, '0);
    settle();

    // The largest pass count, on a single sample that stays put.
    weights = {32'hFFFF_8000, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_8000};
    program_regs(weights, 1, 32'h0000_FFFF);
    send(OP_WRITE, 0, word_t'(32'h0003_8000));
    send(OP_RUN, 0, '0);
    send(OP_READ, 0, '0);
    settle();

    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      random_phase(phase_no);
      phase_no++;
    end

    settle();
    if (mismatches == 0 && words_due == 0) begin
      $display("periodic_five_point_stencil_top verification clean");
    end else begin
      $display("periodic_five_point_stencil_top verification failed");
    end
    $finish;
  end

endmodule
